// File: src/ttbs_pkg.sv
// Shared types, constants and the byte classifier of the token boundary scanner.
package ttbs_pkg;

    localparam int LENGTH_BITS_DEF    = 16;
    localparam int OUT_LEN_BITS       = 16;
    localparam int ITEM_QUEUE_DEPTH   = 2;
    localparam int RESULT_QUEUE_DEPTH = 4;

    // byte classes, the only view of a byte the scanner needs
    typedef enum logic [3:0] {
        C_ALPHA  = 4'd0,
        C_DIGIT  = 4'd1,
        C_WHITE  = 4'd2,
        C_BKSP   = 4'd3,
        C_DOT    = 4'd4,
        C_COMMA  = 4'd5,
        C_QEXCL  = 4'd6,
        C_HASH   = 4'd7,
        C_AT     = 4'd8,
        C_SINGLE = 4'd9,
        C_IDENT  = 4'd10,
        C_SIGN   = 4'd11,
        C_OTHER  = 4'd12
    } t_cls;

    typedef struct packed {
        logic eot;
        t_cls cls;
    } t_item;

    typedef struct packed {
        logic [OUT_LEN_BITS-1:0] len;
        logic                    too_long;
        logic                    last;
    } t_result;

    function automatic t_cls classify(input logic [7:0] b);
        t_cls c;
        if (b[7] || (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A)) begin
            c = C_ALPHA;
        end else if (b >= 8'h30 && b <= 8'h39) begin
            c = C_DIGIT;
        end else begin
            case (b)
                8'h20, 8'h09, 8'h0A, 8'h0D, 8'h0C: c = C_WHITE;
                8'h08:                             c = C_BKSP;
                8'h2E:                             c = C_DOT;
                8'h2C:                             c = C_COMMA;
                8'h3F, 8'h21:                      c = C_QEXCL;
                8'h23:                             c = C_HASH;
                8'h40:                             c = C_AT;
                8'h27, 8'h22, 8'h3A, 8'h3B, 8'h28, 8'h29,
                8'h7B, 8'h7D, 8'h5B, 8'h5D:        c = C_SINGLE;
                8'h5F, 8'h24:                      c = C_IDENT;
                8'h2D, 8'h2B:                      c = C_SIGN;
                default:                           c = C_OTHER;
            endcase
        end
        return c;
    endfunction

endpackage

// File: src/ttbs_front.sv
// Input side: classify each incoming byte and hold items in a short queue for the engine.
module ttbs_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                push,
    output logic                full,
    input  logic [7:0]          i_text_byte,
    input  logic                i_end_of_text,
    output logic                o_valid,
    output ttbs_pkg::t_item     o_item,
    input  logic                i_pop
);

    localparam int DEPTH = ttbs_pkg::ITEM_QUEUE_DEPTH;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);

    ttbs_pkg::t_item r_mem [DEPTH];
    logic [AW-1:0]   r_wp, r_rp;
    logic [CW-1:0]   r_cnt;
    ttbs_pkg::t_item w_item;
    logic            w_wr, w_rd;

    always_comb begin
        w_item.eot = i_end_of_text;
        w_item.cls = ttbs_pkg::classify(i_text_byte);
    end

    assign full    = (r_cnt == CW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_mem[r_rp];
    assign w_wr    = push && !full;
    assign w_rd    = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wp] <= w_item;
        end
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_wr) r_wp <= r_wp + AW'(1);
            if (w_rd) r_rp <= r_rp + AW'(1);
            if (w_wr && !w_rd) r_cnt <= r_cnt + CW'(1);
            else if (w_rd && !w_wr) r_cnt <= r_cnt - CW'(1);
        end
    end

endmodule

// File: src/ttbs_engine.sv
// Back side: scanner FSM stepping a byte class a cycle unless results stall; replays given-back bytes.
module ttbs_engine #(
    parameter int LENGTH_BITS = ttbs_pkg::LENGTH_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  ttbs_pkg::t_item     i_item,
    output logic                o_pop,
    output logic                o_push,
    output ttbs_pkg::t_result   o_result,
    input  logic                i_full
);

    localparam int OW = ttbs_pkg::OUT_LEN_BITS;
    localparam int EW = (LENGTH_BITS > OW) ? LENGTH_BITS : OW;

    typedef enum logic [3:0] {
        S_INIT    = 4'd0,
        S_WHITE   = 4'd1,
        S_WORD    = 4'd2,
        S_WDOT    = 4'd3,
        S_WDOTLET = 4'd4,
        S_ABBRDOT = 4'd5,
        S_ABBR    = 4'd6,
        S_NUM     = 4'd7,
        S_NDOT    = 4'd8,
        S_NDOTLET = 4'd9,
        S_SYM     = 4'd10,
        S_PUNCT   = 4'd11,
        S_PRUN    = 4'd12,
        S_TAG     = 4'd13,
        S_TAGID   = 4'd14
    } t_scan_state;

    typedef enum logic [1:0] {
        ACT_GO        = 2'd0,
        ACT_TAKEN_END = 2'd1,
        ACT_END       = 2'd2
    } t_act;

    t_scan_state         r_state, n_state;
    logic [LENGTH_BITS-1:0] r_count, n_count;
    ttbs_pkg::t_cls      r_rep [3];
    ttbs_pkg::t_cls      n_rep [3];
    logic [1:0]          r_rc, n_rc;
    ttbs_pkg::t_cls      r_pq [3];
    ttbs_pkg::t_cls      n_pq [3];
    logic [1:0]          r_pn, n_pn;
    logic                r_eot, n_eot;
    logic                r_busy, n_busy;
    logic                r_hold_v, n_hold_v;
    ttbs_pkg::t_result   r_hold, n_hold;

    ttbs_pkg::t_cls      w_head;
    logic                w_cnt_zero;
    t_act                w_sym_act, w_act;
    t_scan_state         w_sym_next, w_next;
    logic [1:0]          w_back_raw, w_flush_back, w_back;
    logic [LENGTH_BITS-1:0] w_cnt_inc, w_e_cnt, w_e_val;
    logic                w_e_sat;
    logic [EW-1:0]       w_e_wide;
    logic                w_can_emit;

    assign w_head     = r_pq[0];
    assign w_cnt_zero = (r_count == '0);
    assign w_cnt_inc  = (&r_count) ? r_count : r_count + LENGTH_BITS'(1);

    // symbol-run rules, shared by several states
    always_comb begin
        w_sym_act  = ACT_END;
        w_sym_next = S_INIT;
        case (w_head)
            ttbs_pkg::C_ALPHA, ttbs_pkg::C_DIGIT, ttbs_pkg::C_WHITE: begin
                w_sym_act = ACT_END;
            end
            ttbs_pkg::C_DOT, ttbs_pkg::C_COMMA, ttbs_pkg::C_QEXCL: begin
                if (w_cnt_zero) begin
                    w_sym_act  = ACT_GO;
                    w_sym_next = S_PUNCT;
                end
            end
            ttbs_pkg::C_AT, ttbs_pkg::C_SINGLE: begin
                if (w_cnt_zero) begin
                    w_sym_act  = ACT_TAKEN_END;
                    w_sym_next = S_SYM;
                end
            end
            default: begin
                w_sym_act  = ACT_GO;
                w_sym_next = S_SYM;
            end
        endcase
    end

    // one scanner step on the head of the replay queue
    always_comb begin
        w_act      = ACT_END;
        w_next     = S_INIT;
        w_back_raw = 2'd0;
        case (r_state)
            S_INIT: begin
                if (w_head == ttbs_pkg::C_ALPHA) begin
                    w_act = ACT_GO; w_next = S_WORD;
                end else if (w_head == ttbs_pkg::C_DIGIT) begin
                    w_act = ACT_GO; w_next = S_NUM;
                end else if (w_head == ttbs_pkg::C_HASH || w_head == ttbs_pkg::C_AT) begin
                    w_act = ACT_GO; w_next = S_TAG;
                end else if (w_head == ttbs_pkg::C_WHITE || w_head == ttbs_pkg::C_BKSP) begin
                    w_act = ACT_GO; w_next = S_WHITE;
                end else begin
                    w_act = w_sym_act; w_next = w_sym_next;
                end
            end
            S_WHITE: begin
                if (w_head == ttbs_pkg::C_WHITE || w_head == ttbs_pkg::C_BKSP) begin
                    w_act = ACT_GO; w_next = S_WHITE;
                end
            end
            S_WORD: begin
                if (w_head == ttbs_pkg::C_ALPHA || w_head == ttbs_pkg::C_DIGIT) begin
                    w_act = ACT_GO; w_next = S_WORD;
                end else if (w_head == ttbs_pkg::C_DOT) begin
                    w_act = ACT_GO; w_next = S_WDOT;
                end
            end
            S_WDOT: begin
                if (w_head == ttbs_pkg::C_ALPHA) begin
                    w_act = ACT_GO; w_next = S_WDOTLET;
                end else begin
                    w_back_raw = 2'd1;
                end
            end
            S_WDOTLET: begin
                if (w_head == ttbs_pkg::C_DOT) begin
                    w_act = ACT_GO; w_next = S_ABBRDOT;
                end else if (w_head == ttbs_pkg::C_DIGIT) begin
                    w_act = ACT_GO; w_next = S_NUM;
                end else begin
                    w_back_raw = 2'd2;
                end
            end
            S_ABBRDOT: begin
                if (w_head == ttbs_pkg::C_ALPHA) begin
                    w_act = ACT_GO; w_next = S_ABBR;
                end
            end
            S_ABBR: begin
                if (w_head == ttbs_pkg::C_DOT) begin
                    w_act = ACT_GO; w_next = S_ABBRDOT;
                end else if (w_head == ttbs_pkg::C_ALPHA) begin
                    w_back_raw = 2'd2;
                end else begin
                    w_back_raw = 2'd1;
                end
            end
            S_NUM: begin
                if (w_head == ttbs_pkg::C_ALPHA || w_head == ttbs_pkg::C_DIGIT) begin
                    w_act = ACT_GO; w_next = S_NUM;
                end else if (w_head == ttbs_pkg::C_DOT || w_head == ttbs_pkg::C_COMMA) begin
                    w_act = ACT_GO; w_next = S_NDOT;
                end
            end
            S_NDOT: begin
                if (w_head == ttbs_pkg::C_ALPHA) begin
                    w_act = ACT_GO; w_next = S_NDOTLET;
                end else if (w_head == ttbs_pkg::C_DIGIT || w_head == ttbs_pkg::C_SIGN) begin
                    w_act = ACT_GO; w_next = S_NUM;
                end else begin
                    w_back_raw = 2'd1;
                end
            end
            S_NDOTLET: begin
                if (w_head == ttbs_pkg::C_DIGIT) begin
                    w_act = ACT_GO; w_next = S_NUM;
                end else begin
                    w_back_raw = 2'd2;
                end
            end
            S_SYM: begin
                w_act = w_sym_act; w_next = w_sym_next;
            end
            S_PUNCT: begin
                if (w_head == ttbs_pkg::C_AT || w_head == ttbs_pkg::C_HASH) begin
                    w_act = ACT_GO; w_next = S_SYM;
                end else if (w_head == ttbs_pkg::C_DOT || w_head == ttbs_pkg::C_COMMA ||
                             w_head == ttbs_pkg::C_QEXCL) begin
                    w_act = ACT_GO; w_next = S_PRUN;
                end
            end
            S_PRUN: begin
                if (w_head == ttbs_pkg::C_DOT || w_head == ttbs_pkg::C_COMMA ||
                    w_head == ttbs_pkg::C_QEXCL) begin
                    w_act = ACT_GO; w_next = S_PRUN;
                end
            end
            S_TAG: begin
                if (w_head == ttbs_pkg::C_ALPHA) begin
                    w_act = ACT_GO; w_next = S_TAGID;
                end else begin
                    w_act = w_sym_act; w_next = w_sym_next;
                end
            end
            S_TAGID: begin
                if (w_head == ttbs_pkg::C_ALPHA || w_head == ttbs_pkg::C_DIGIT ||
                    w_head == ttbs_pkg::C_IDENT) begin
                    w_act = ACT_GO; w_next = S_TAGID;
                end
            end
            default: begin
                w_act = ACT_END;
            end
        endcase
    end

    // bytes to give back when end of text cuts an open token
    always_comb begin
        case (r_state)
            S_WDOT, S_NDOT:       w_flush_back = 2'd1;
            S_WDOTLET, S_NDOTLET: w_flush_back = 2'd2;
            default:              w_flush_back = 2'd0;
        endcase
    end

    // length of the token being closed, saturated and cut to the port width
    always_comb begin
        logic [1:0] raw;
        raw = (r_pn != 2'd0) ? ((w_act == ACT_END) ? w_back_raw : 2'd0) : w_flush_back;
        w_back  = (raw > r_rc) ? r_rc : raw;
        w_e_cnt = (r_pn != 2'd0 && w_act == ACT_TAKEN_END) ? w_cnt_inc : r_count;
        w_e_sat = &w_e_cnt;
        w_e_val = w_e_sat ? w_e_cnt : w_e_cnt - LENGTH_BITS'(w_back);
        w_e_wide = EW'(w_e_val);
    end

    assign w_can_emit = !r_hold_v || !i_full;

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_rep    = r_rep;
        n_rc     = r_rc;
        n_pq     = r_pq;
        n_pn     = r_pn;
        n_eot    = r_eot;
        n_busy   = r_busy;
        n_hold_v = r_hold_v;
        n_hold   = r_hold;
        o_pop    = 1'b0;
        o_push   = 1'b0;
        o_result = r_hold;
        o_result.last = 1'b0;

        if (!r_busy) begin
            if (i_valid) begin
                o_pop   = 1'b1;
                n_busy  = 1'b1;
                n_eot   = i_item.eot;
                n_pq[0] = i_item.cls;
                n_pn    = i_item.eot ? 2'd0 : 2'd1;
            end
        end else if (r_pn != 2'd0) begin
            if (w_act == ACT_GO) begin
                n_state = w_next;
                n_count = w_cnt_inc;
                n_rep[0] = w_head;
                n_rep[1] = r_rep[0];
                n_rep[2] = r_rep[1];
                n_rc    = (r_rc == 2'd3) ? r_rc : r_rc + 2'd1;
                n_pq[0] = r_pq[1];
                n_pq[1] = r_pq[2];
                n_pn    = r_pn - 2'd1;
            end else if (w_can_emit) begin
                o_push   = r_hold_v;
                n_hold_v = 1'b1;
                n_hold.len      = w_e_wide[OW-1:0];
                n_hold.too_long = w_e_sat;
                n_hold.last     = 1'b0;
                n_state = S_INIT;
                n_count = '0;
                n_rc    = 2'd0;
                if (w_act == ACT_TAKEN_END) begin
                    n_pq[0] = r_pq[1];
                    n_pq[1] = r_pq[2];
                    n_pn    = r_pn - 2'd1;
                end else begin
                    // requeue the given-back bytes ahead of the current one
                    case (w_back)
                        2'd1: begin
                            n_pq[0] = r_rep[0];
                            n_pq[1] = r_pq[0];
                            n_pq[2] = r_pq[1];
                            n_pn    = r_pn + 2'd1;
                        end
                        2'd2: begin
                            n_pq[0] = r_rep[1];
                            n_pq[1] = r_rep[0];
                            n_pq[2] = r_pq[0];
                            n_pn    = r_pn + 2'd2;
                        end
                        default: begin
                            n_pn = r_pn;
                        end
                    endcase
                end
            end
        end else if (r_eot && r_state != S_INIT) begin
            if (w_can_emit) begin
                o_push   = r_hold_v;
                n_hold_v = 1'b1;
                n_hold.len      = w_e_wide[OW-1:0];
                n_hold.too_long = w_e_sat;
                n_hold.last     = 1'b0;
                n_state = S_INIT;
                n_count = '0;
                n_rc    = 2'd0;
                n_pn    = w_back;
                case (w_back)
                    2'd1: n_pq[0] = r_rep[0];
                    2'd2: begin
                        n_pq[0] = r_rep[1];
                        n_pq[1] = r_rep[0];
                    end
                    default: n_pq[0] = r_pq[0];
                endcase
            end
        end else if (w_can_emit) begin
            // close the item: the held result is its last one
            o_push        = r_hold_v;
            o_result.last = 1'b1;
            n_hold_v      = 1'b0;
            n_busy        = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pq   <= n_pq;
        r_rep  <= n_rep;
        r_hold <= n_hold;
        if (!i_rst_n) begin
            r_state  <= S_INIT;
            r_count  <= '0;
            r_rc     <= 2'd0;
            r_pn     <= 2'd0;
            r_eot    <= 1'b0;
            r_busy   <= 1'b0;
            r_hold_v <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_rc     <= n_rc;
            r_pn     <= n_pn;
            r_eot    <= n_eot;
            r_busy   <= n_busy;
            r_hold_v <= n_hold_v;
        end
    end

endmodule

// File: src/ttbs_outq.sv
// Result queue between the engine and the output port.
module ttbs_outq (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  ttbs_pkg::t_result   i_data,
    output logic                o_full,
    output logic                empty,
    input  logic                pop,
    output ttbs_pkg::t_result   o_data
);

    localparam int DEPTH = ttbs_pkg::RESULT_QUEUE_DEPTH;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);

    ttbs_pkg::t_result r_mem [DEPTH];
    logic [AW-1:0]     r_wp, r_rp;
    logic [CW-1:0]     r_cnt;
    logic              w_wr, w_rd;

    assign o_full = (r_cnt == CW'(DEPTH));
    assign empty  = (r_cnt == '0);
    assign o_data = r_mem[r_rp];
    assign w_wr   = i_push && !o_full;
    assign w_rd   = pop && !empty;

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wp] <= i_data;
        end
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_wr) r_wp <= r_wp + AW'(1);
            if (w_rd) r_rp <= r_rp + AW'(1);
            if (w_wr && !w_rd) r_cnt <= r_cnt + CW'(1);
            else if (w_rd && !w_wr) r_cnt <= r_cnt - CW'(1);
        end
    end

endmodule

// File: src/text_token_boundary_scanner.sv
// Top level of the text token boundary scanner.
// Push one text byte per transfer (push high, full low) with i_end_of_text low,
// or an end-of-text item with i_end_of_text high to flush the open token.
// Each item yields zero to four token lengths on the result side; the oldest
// waits on o_token_length/o_too_long/o_last_of_run while empty is low and moves
// on a transfer with pop high. o_last_of_run marks the final result of an item.
// A classifier and a two-entry item queue sit in front of the scanner engine.
// For a plain byte the engine loads the item, takes a scan step and closes it,
// plus a step for each byte scanned again after a token ends short and a flush
// step at end of text. It steps once per cycle unless a full result queue holds
// it, and takes no new item until it has closed the last one. A result enters
// the result queue at the next token end or at the close of its item.
// When the receiver stalls, the four-entry result queue fills, the engine holds
// its step, the item queue fills and full rises; nothing is dropped.
// Reset (synchronous, i_rst_n low) empties both queues and returns the scanner
// to its initial state with no open token.
module text_token_boundary_scanner #(
    parameter int LENGTH_BITS = ttbs_pkg::LENGTH_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_text_byte,
    input  logic        i_end_of_text,
    output logic        empty,
    input  logic        pop,
    output logic [15:0] o_token_length,
    output logic        o_too_long,
    output logic        o_last_of_run
);

    logic              w_item_valid, w_item_pop;
    ttbs_pkg::t_item   w_item;
    logic              w_res_push, w_res_full;
    ttbs_pkg::t_result w_res, w_out;

    ttbs_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_text_byte   (i_text_byte),
        .i_end_of_text (i_end_of_text),
        .o_valid       (w_item_valid),
        .o_item        (w_item),
        .i_pop         (w_item_pop)
    );

    ttbs_engine #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_engine (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_item_valid),
        .i_item   (w_item),
        .o_pop    (w_item_pop),
        .o_push   (w_res_push),
        .o_result (w_res),
        .i_full   (w_res_full)
    );

    ttbs_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push),
        .i_data  (w_res),
        .o_full  (w_res_full),
        .empty   (empty),
        .pop     (pop),
        .o_data  (w_out)
    );

    assign o_token_length = w_out.len;
    assign o_too_long     = w_out.too_long;
    assign o_last_of_run  = w_out.last;

endmodule
